// ----- src/svss_pkg.sv -----
// shared types and constants for the small value set store
package svss_pkg;

  localparam int unsigned CapacityDefault = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LimitW = 5;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              del;
    logic              clr;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

// ----- src/svss_in_if.sv -----
// input channel: operation and value
interface svss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// ----- src/svss_out_if.sv -----
// result channel: status, position and count
interface svss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] position;
  logic [4:0] count;

  modport source (output valid, output status, output position, output count, input ready);
  modport sink (input valid, input status, input position, input count, output ready);
endinterface

// ----- src/svss_cfg_if.sv -----
// configuration write channel for the size limit
interface svss_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/svss_cell.sv -----
// one storage cell: entry, valid bit, match flag, shift from upper neighbor
module svss_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CntW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  svss_pkg::cell_cmd_t       cmd_i,
  input  logic [CntW-1:0]           count_i,
  input  logic                      shift_i,
  input  logic [svss_pkg::ValueW-1:0] nxt_entry_i,
  input  logic                      nxt_valid_i,
  output logic [svss_pkg::ValueW-1:0] entry_o,
  output logic                      valid_o,
  output logic                      hit_o
);
  import svss_pkg::*;

  logic [ValueW-1:0] entry_q, entry_d;
  logic              valid_q, valid_d;
  logic              hit_q;
  logic              load_here;

  assign load_here = cmd_i.ins && (count_i == CntW'(Index));

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (load_here) begin
      entry_d = cmd_i.value;
      valid_d = 1'b1;
    end else if (cmd_i.del && shift_i) begin
      // take the upper neighbor's word to close the gap
      entry_d = nxt_entry_i;
      valid_d = nxt_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (cmd_i.cmp) begin
      hit_q <= valid_q && (entry_q == cmd_i.value);
    end
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

// ----- src/small_value_set_store_core.sv -----
// top level: controller and the row of storage cells
//
//   channel  | dir | fields                  | accepted when
//   in_i     | in  | op, value               | valid & ready
//   out_o    | out | status, position, count | valid & ready
//   cfg_i    | in  | data (size limit)       | valid & ready
//
// an item goes through accept, compare in every cell, then update and result
// the compare stage registers each cell's match flag before the shift/insert
// the result sits in an output register, so the next item is taken while it waits
// a stalled result holds the update stage; reset empties the set, no clearing pass
module small_value_set_store_core #(
  parameter int unsigned Capacity = svss_pkg::CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svss_in_if.sink     in_i,
  svss_out_if.source  out_o,
  svss_cfg_if.sink    cfg_i
);
  import svss_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned PosW = $clog2(Capacity);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_e;

  state_e            state_q;
  op_e               op_q;
  logic [ValueW-1:0] value_q;
  logic [CntW-1:0]   count_q;
  logic [LimitW-1:0] limit_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [3:0]        pos_q;
  logic [4:0]        cnt_out_q;

  cell_cmd_t         cmd;
  logic              fire;
  logic [Capacity-1:0] hit_vec, valid_vec, ge_vec;
  logic [ValueW-1:0] entry_vec [Capacity+1];
  logic [Capacity:0] nvalid_vec;
  logic              hit_any;
  logic [PosW-1:0]   hit_pos;
  logic [CmpW-1:0]   limit_eff, count_ext;
  status_e           status_d;
  logic [PosW-1:0]   pos_d;
  logic [CntW-1:0]   count_d;
  logic              ins_ok, del_ok;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign fire = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);

  // match position: at most one cell hits since the entries are distinct
  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      if (hit_vec[i]) begin
        hit_pos = hit_pos | PosW'(i);
      end
    end
  end

  // cells at or above the deleted one take their upper neighbor's word
  always_comb begin
    for (int unsigned i = 0; i < Capacity; i++) begin
      ge_vec[i] = |(hit_vec & ({Capacity{1'b1}} >> (Capacity - 1 - i)));
    end
  end

  assign hit_any   = |hit_vec;
  assign limit_eff = (CmpW'(limit_q) > CmpW'(Capacity)) ? CmpW'(Capacity) : CmpW'(limit_q);
  assign count_ext = CmpW'(count_q);

  always_comb begin
    status_d = ST_OK;
    pos_d    = '0;
    count_d  = count_q;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        if (hit_any) begin
          status_d = ST_MISS;
        end else if (count_ext >= limit_eff) begin
          status_d = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          pos_d   = PosW'(count_q);
          count_d = count_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!hit_any) begin
          status_d = ST_MISS;
        end else begin
          del_ok  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_FIND: begin
        if (!hit_any) begin
          status_d = ST_MISS;
        end else begin
          pos_d = hit_pos;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd.cmp   = (state_q == S_CMP);
    cmd.ins   = fire && ins_ok;
    cmd.del   = fire && del_ok;
    cmd.clr   = fire && (op_q == OP_CLEAR);
    cmd.value = value_q;
  end

  assign entry_vec[Capacity]  = '0;
  assign nvalid_vec[Capacity] = 1'b0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    svss_cell #(
      .Index (g),
      .CntW  (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .shift_i     (ge_vec[g]),
      .nxt_entry_i (entry_vec[g+1]),
      .nxt_valid_i (nvalid_vec[g+1]),
      .entry_o     (entry_vec[g]),
      .valid_o     (nvalid_vec[g]),
      .hit_o       (hit_vec[g])
    );
  end

  assign valid_vec = nvalid_vec[Capacity-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= cfg_i.data;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            count_q <= count_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= op_e'(in_i.op);
      value_q <= in_i.value;
    end
    if (fire) begin
      status_q  <= status_d;
      pos_q     <= 4'(pos_d);
      cnt_out_q <= 5'(count_d);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.position = pos_q;
  assign out_o.count    = cnt_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> $onehot0(hit_vec))
    else $error("value matched in more than one cell");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_q == OP_CLEAR) |=> (count_q == '0) && (valid_vec == '0))
    else $error("clear left entries behind");

endmodule

// ----- verif/small_value_set_store_core_test.sv -----
// self-checking testbench for the small value set store core
module small_value_set_store_core_test;
  import svss_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int Cap = CapacityDefault;
  localparam int QuietLimit = 500;
  localparam int PoolSize = 24;
  localparam int RandPhases = 12;
  localparam int OpsPerPhase = 58;

  typedef struct {
    op_e         op;
    logic [31:0] value;
  } set_op_t;

  typedef struct {
    status_e    status;
    logic [3:0] position;
    logic [4:0] count;
  } set_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  svss_in_if  op_ch ();
  svss_out_if res_ch ();
  svss_cfg_if cfg_ch ();

  small_value_set_store_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // predicted contents of the set
  logic [31:0] held [Cap];
  int unsigned held_n = 0;
  logic [4:0]  limit_reg = LimitReset;

  set_op_t     ops_to_send [$];
  set_answer_t answers_due [$];
  set_op_t     next_op;
  set_answer_t due;
  logic [31:0] value_pool [PoolSize];

  int fail_count = 0;
  int send_wait = 0;
  int take_wait = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 100) $display("mismatch: %s", what);
  endtask

  function automatic int draw_pause();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // applies one operation to the predicted set and returns its result word
  function automatic set_answer_t compute_set_answer(op_e op, logic [31:0] v);
    set_answer_t a;
    int at;
    int unsigned lim;
    a.status = ST_OK;
    a.position = '0;
    at = -1;
    lim = (limit_reg < Cap) ? limit_reg : Cap;
    for (int i = 0; i < held_n; i++) begin
      if (at < 0 && held[i] == v) at = i;
    end
    case (op)
      OP_INSERT: begin
        if (at >= 0) begin
          a.status = ST_MISS;
        end else if (held_n >= lim) begin
          a.status = ST_FULL;
        end else begin
          held[held_n] = v;
          a.position = held_n[3:0];
          held_n++;
        end
      end
      OP_DELETE: begin
        if (at < 0) begin
          a.status = ST_MISS;
        end else begin
          for (int i = at; i + 1 < held_n; i++) held[i] = held[i + 1];
          held_n--;
        end
      end
      OP_FIND: begin
        if (at < 0) a.status = ST_MISS;
        else a.position = at[3:0];
      end
      default: held_n = 0;
    endcase
    a.count = held_n[4:0];
    return a;
  endfunction

  function automatic op_e pick_op();
    int unsigned r = $urandom_range(0, 99);
    if (r < 50) return OP_INSERT;
    if (r < 68) return OP_DELETE;
    if (r < 98) return OP_FIND;
    return OP_CLEAR;
  endfunction

  // mostly values from a small pool so that hits, duplicates and full sets occur
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return value_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  task automatic queue_op(input op_e op, input logic [31:0] v);
    set_op_t o;
    o.op = op;
    o.value = v;
    ops_to_send.push_back(o);
  endtask

  task automatic wait_idle();
    while (ops_to_send.size() != 0 || op_ch.valid || answers_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [4:0] lim);
    wait_idle();
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= lim;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limit_reg = lim;
    @(negedge clk_i);
  endtask

  // op driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      op_ch.valid <= 1'b0;
      send_wait = draw_pause();
    end else begin
      if (op_ch.valid && op_ch.ready)
        answers_due.push_back(compute_set_answer(op_e'(op_ch.op), op_ch.value));
      if (!op_ch.valid || op_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          op_ch.valid <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          next_op = ops_to_send.pop_front();
          op_ch.valid <= 1'b1;
          op_ch.op <= next_op.op;
          op_ch.value <= next_op.value;
          send_wait = draw_pause();
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      take_wait = draw_pause();
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result word with nothing awaited");
        end else begin
          due = answers_due.pop_front();
          if (res_ch.status !== due.status)
            report_mismatch($sformatf("status %0d, want %0d", res_ch.status, due.status));
          if (res_ch.position !== due.position)
            report_mismatch($sformatf("position %0d, want %0d", res_ch.position,
                                      due.position));
          if (res_ch.count !== due.count)
            report_mismatch($sformatf("count %0d, want %0d", res_ch.count, due.count));
        end
        take_wait = draw_pause();
      end
      if (take_wait > 0) begin
        take_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(negedge clk_i);
    $display("[small_value_set_store_core] ERROR");
    $finish;
  end

  initial begin
    op_ch.valid = 1'b0;
    op_ch.op = OP_INSERT;
    op_ch.value = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h5555_5555;
    value_pool[6] = 32'hAAAA_AAAA;
    for (int i = 7; i < PoolSize; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // limit at its reset value: extremes, duplicate, hits and misses, clear
    queue_op(OP_INSERT, 32'h8000_0000);
    queue_op(OP_INSERT, 32'h7FFF_FFFF);
    queue_op(OP_INSERT, 32'h0000_0000);
    queue_op(OP_INSERT, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 32'h7FFF_FFFF);
    queue_op(OP_FIND, 32'hFFFF_FFFF);
    queue_op(OP_FIND, 32'h5555_5555);
    queue_op(OP_DELETE, 32'h7FFF_FFFF);
    queue_op(OP_FIND, 32'hFFFF_FFFF);
    queue_op(OP_DELETE, 32'h7FFF_FFFF);
    queue_op(OP_FIND, 32'h8000_0000);
    queue_op(OP_CLEAR, 32'hAAAA_AAAA);
    queue_op(OP_DELETE, 32'h0000_0000);
    queue_op(OP_FIND, 32'h0000_0000);
    queue_op(OP_INSERT, 32'h5A5A_5A5A);
    queue_op(OP_INSERT, 32'hA5A5_A5A5);
    queue_op(OP_INSERT, 32'h0000_0001);

    // zero limit: new values are refused, duplicate check still wins
    write_limit(5'd0);
    queue_op(OP_INSERT, 32'h0000_0007);
    queue_op(OP_INSERT, 32'h0000_0001);
    queue_op(OP_FIND, 32'h0000_0001);

    // limit below the count: full until enough entries are gone
    write_limit(5'd2);
    queue_op(OP_INSERT, 32'h0000_0009);
    queue_op(OP_DELETE, 32'h0000_0001);
    queue_op(OP_INSERT, 32'h0000_0009);
    queue_op(OP_DELETE, 32'h5A5A_5A5A);
    queue_op(OP_INSERT, 32'h0000_0009);

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: write_limit(5'd31);
        1: write_limit(5'd16);
        2: write_limit(5'd1);
        3: write_limit(5'd0);
        default: write_limit(5'($urandom_range(0, 31)));
      endcase
      calm = (p % 3 == 1);
      for (int k = 0; k < OpsPerPhase; k++) queue_op(pick_op(), pick_value());
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[small_value_set_store_core] OK");
    end else begin
      $display("[small_value_set_store_core] ERROR");
    end
    $finish;
  end

endmodule
